// ----- sv/pvsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvsd_pkg
// Shared widths and constants of the prefix varint stream decoder.
// ----------------------------------------------------------------------------
package pvsd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 60;
    localparam int unsigned CountW = 4;
    localparam int unsigned OwedW  = 3;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [ValueW-1:0] t_value;
    typedef logic [CountW-1:0] t_count;
    typedef logic [OwedW-1:0]  t_owed;

    localparam t_byte MaskLen1 = 8'h7F;
    localparam t_byte MaskLen2 = 8'h3F;
    localparam t_byte MaskLen4 = 8'h1F;
    localparam t_byte MaskLen8 = 8'h0F;

    localparam t_count Len1 = 4'd1;
    localparam t_count Len2 = 4'd2;
    localparam t_count Len4 = 4'd4;
    localparam t_count Len8 = 4'd8;

    localparam t_owed Owed2 = 3'd1;
    localparam t_owed Owed4 = 3'd3;
    localparam t_owed Owed8 = 3'd7;

endpackage
`default_nettype wire

// ----- sv/prefix_varint_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder_unit
// Decodes a byte stream of prefix-length unsigned integers, one byte a cycle while no held result blocks a final byte.
//
// Input channel: i_in_valid / o_in_stall carry one byte per transaction.
// Output channel: o_out_valid / i_out_stall carry one decoded integer and its
// encoded length (1, 2, 4 or 8 bytes) per transaction.
// A byte is taken into an input register, then merged into the running value
// and, if it ends an integer, written to the result register, which drives
// the output channel. Throughput, set by the single register-to-register
// pass of the decode step, is one byte per cycle while no held result blocks
// a final byte.
// When the receiver stalls, a held result blocks only a byte that would
// produce another result; bytes that end no integer keep flowing, and one
// further byte waits in the input register. o_in_stall rises only when that
// register holds a byte that cannot move.
// Reset clears the length state, both valid flags and any partial integer;
// the next byte is treated as a first byte.
// ----------------------------------------------------------------------------
module prefix_varint_stream_decoder_unit (
    input  wire  logic                    i_clk,
    input  wire  logic                    i_rst_n,
    input  wire  logic                    i_in_valid,
    input  wire  pvsd_pkg::t_byte         i_in_byte,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  wire  logic                    i_out_stall,
    output pvsd_pkg::t_value              o_value,
    output pvsd_pkg::t_count              o_byte_count
);

    logic               r_in_valid;
    pvsd_pkg::t_byte    r_in_byte;
    pvsd_pkg::t_owed    r_owed;
    pvsd_pkg::t_value   r_partial;
    pvsd_pkg::t_count   r_total;
    logic               r_out_valid;
    pvsd_pkg::t_value   r_value;
    pvsd_pkg::t_count   r_count;

    pvsd_pkg::t_owed    n_owed;
    pvsd_pkg::t_value   n_partial;
    pvsd_pkg::t_count   n_total;
    logic               n_emit;
    pvsd_pkg::t_value   n_value;
    pvsd_pkg::t_count   n_count;
    pvsd_pkg::t_value   shifted;
    logic               advance;
    logic               in_take;

    assign shifted = {r_partial[pvsd_pkg::ValueW-pvsd_pkg::ByteW-1:0], r_in_byte};

    always_comb begin
        n_owed    = r_owed;
        n_partial = r_partial;
        n_total   = r_total;
        n_emit    = 1'b0;
        n_value   = shifted;
        n_count   = r_total;
        if (r_owed == '0) begin
            if (!r_in_byte[7]) begin
                n_emit  = 1'b1;
                n_value = pvsd_pkg::t_value'(r_in_byte & pvsd_pkg::MaskLen1);
                n_count = pvsd_pkg::Len1;
            end else if (!r_in_byte[6]) begin
                n_partial = pvsd_pkg::t_value'(r_in_byte & pvsd_pkg::MaskLen2);
                n_owed    = pvsd_pkg::Owed2;
                n_total   = pvsd_pkg::Len2;
            end else if (!r_in_byte[5]) begin
                n_partial = pvsd_pkg::t_value'(r_in_byte & pvsd_pkg::MaskLen4);
                n_owed    = pvsd_pkg::Owed4;
                n_total   = pvsd_pkg::Len4;
            end else begin
                n_partial = pvsd_pkg::t_value'(r_in_byte & pvsd_pkg::MaskLen8);
                n_owed    = pvsd_pkg::Owed8;
                n_total   = pvsd_pkg::Len8;
            end
        end else begin
            n_partial = shifted;
            n_owed    = r_owed - pvsd_pkg::t_owed'(1);
            n_emit    = (r_owed == pvsd_pkg::t_owed'(1));
        end
    end

    assign advance    = r_in_valid && (!n_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_owed      <= '0;
            r_partial   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in_byte;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_owed    <= n_owed;
                r_partial <= n_partial;
                r_total   <= n_total;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
                r_value     <= n_value;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_value;
    assign o_byte_count = r_count;

endmodule
`default_nettype wire

// ----- sv/pvsd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvsd_checker
// Port-level checks of the prefix varint stream decoder.
// ----------------------------------------------------------------------------
module pvsd_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire pvsd_pkg::t_byte   i_in_byte,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire pvsd_pkg::t_value  o_value,
    input wire pvsd_pkg::t_count  o_byte_count
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_byte))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
            && $stable(o_byte_count))
        else $error("stalled result changed");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count == pvsd_pkg::Len1
            || o_byte_count == pvsd_pkg::Len2
            || o_byte_count == pvsd_pkg::Len4
            || o_byte_count == pvsd_pkg::Len8)
        else $error("illegal byte count");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_count != pvsd_pkg::Len1 || o_value[59:7] == '0)
            && (o_byte_count != pvsd_pkg::Len2 || o_value[59:14] == '0)
            && (o_byte_count != pvsd_pkg::Len4 || o_value[59:29] == '0))
        else $error("value wider than its length allows");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs active after reset");

endmodule

bind prefix_varint_stream_decoder_unit pvsd_checker u_pvsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_byte    (i_in_byte),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_value      (o_value),
    .o_byte_count (o_byte_count)
);
`default_nettype wire

// ----- sim/prefix_varint_stream_decoder_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder_unit_test
// Self-checking bench for the prefix varint stream decoder. Directed
// boundary integers of every length come first. Random streams of encoded
// integers mixed with raw bytes follow, under several idle and stall mixes.
// Then a long receiver hold-off fills the block, and the sender pauses in
// the middle of an integer. A byte-level decoder model predicts each result.
// ----------------------------------------------------------------------------
module prefix_varint_stream_decoder_unit_test;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports  = 40;

    typedef struct packed {
        pvsd_pkg::t_value value;
        pvsd_pkg::t_count count;
    } t_decoded;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    pvsd_pkg::t_byte  i_in_byte;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             i_out_stall;
    pvsd_pkg::t_value o_value;
    pvsd_pkg::t_count o_byte_count;

    t_decoded         decoded_q[$];
    t_decoded         want;
    pvsd_pkg::t_owed  owed_bytes;
    pvsd_pkg::t_value partial_value;
    pvsd_pkg::t_count total_length;
    int unsigned      error_count;
    int unsigned      cycle_count;
    int unsigned      bytes_sent;
    int unsigned      sender_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      hold_left;

    prefix_varint_stream_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_byte_count (o_byte_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("prefix_varint_stream_decoder_unit verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (error_count < MaxReports) begin
            $display("MISMATCH %s: got 0x%0h expected 0x%0h at cycle %0d",
                     what, got, exp_val, cycle_count);
        end
        error_count++;
    endtask

    task automatic track_byte(input pvsd_pkg::t_byte b);
        if (owed_bytes == '0) begin
            if (!b[7]) begin
                decoded_q.push_back('{value: pvsd_pkg::t_value'(b & pvsd_pkg::MaskLen1),
                                      count: pvsd_pkg::Len1});
            end else if (b[7:6] == 2'b10) begin
                partial_value = pvsd_pkg::t_value'(b & pvsd_pkg::MaskLen2);
                owed_bytes    = pvsd_pkg::Owed2;
                total_length  = pvsd_pkg::Len2;
            end else if (b[7:5] == 3'b110) begin
                partial_value = pvsd_pkg::t_value'(b & pvsd_pkg::MaskLen4);
                owed_bytes    = pvsd_pkg::Owed4;
                total_length  = pvsd_pkg::Len4;
            end else begin
                partial_value = pvsd_pkg::t_value'(b & pvsd_pkg::MaskLen8);
                owed_bytes    = pvsd_pkg::Owed8;
                total_length  = pvsd_pkg::Len8;
            end
        end else begin
            partial_value = {partial_value[pvsd_pkg::ValueW-pvsd_pkg::ByteW-1:0], b};
            owed_bytes    = owed_bytes - pvsd_pkg::t_owed'(1);
            if (owed_bytes == '0) begin
                decoded_q.push_back('{value: partial_value, count: total_length});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with none pending", 64'(o_value), '0);
                end else begin
                    want = decoded_q[0];
                    decoded_q.delete(0);
                    if (o_value !== want.value) begin
                        report_mismatch("value", 64'(o_value), 64'(want.value));
                    end
                    if (o_byte_count !== want.count) begin
                        report_mismatch("byte_count", 64'(o_byte_count),
                                        64'(want.count));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                track_byte(i_in_byte);
            end
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input pvsd_pkg::t_byte b);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_integer(input pvsd_pkg::t_count len, input logic [63:0] bits);
        case (len)
            pvsd_pkg::Len1: begin
                send_byte({1'b0, bits[6:0]});
            end
            pvsd_pkg::Len2: begin
                send_byte({2'b10, bits[13:8]});
                send_byte(bits[7:0]);
            end
            pvsd_pkg::Len4: begin
                send_byte({3'b110, bits[28:24]});
                for (int i = 2; i >= 0; i--) send_byte(bits[8*i +: 8]);
            end
            default: begin
                send_byte({3'b111, bits[60], bits[59:56]});
                for (int i = 6; i >= 0; i--) send_byte(bits[8*i +: 8]);
            end
        endcase
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic run_random_stream(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned target);
        int unsigned start;
        int unsigned pick;
        logic [63:0] bits;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < target) begin
            pick = $urandom_range(99);
            bits = {$urandom(), $urandom()};
            if (pick < 25)      send_integer(pvsd_pkg::Len1, bits);
            else if (pick < 45) send_integer(pvsd_pkg::Len2, bits);
            else if (pick < 65) send_integer(pvsd_pkg::Len4, bits);
            else if (pick < 85) send_integer(pvsd_pkg::Len8, bits);
            else                send_byte(pvsd_pkg::t_byte'($urandom_range(255)));
        end
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_integer(pvsd_pkg::Len1, 64'h0);
        send_integer(pvsd_pkg::Len1, 64'h7F);
        send_integer(pvsd_pkg::Len2, 64'h0);
        send_integer(pvsd_pkg::Len2, 64'h3FFF);
        send_integer(pvsd_pkg::Len4, 64'h0);
        send_integer(pvsd_pkg::Len4, 64'h1FFF_FFFF);
        send_integer(pvsd_pkg::Len8, 64'h0);
        send_integer(pvsd_pkg::Len8, 64'h1FFF_FFFF_FFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_free_flow();
        run_random_stream(0, 0, 290);
    endtask

    task automatic test_random_sender_idle();
        run_random_stream(77, 0, 290);
    endtask

    task automatic test_random_receiver_stall();
        run_random_stream(0, 77, 290);
    endtask

    task automatic test_random_both_idle();
        run_random_stream(24, 24, 290);
    endtask

    task automatic test_backpressure_fill();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 300;
        for (int i = 0; i < 40; i++) begin
            send_integer(pvsd_pkg::Len1, {$urandom(), $urandom()});
        end
        for (int i = 0; i < 3; i++) begin
            send_integer(pvsd_pkg::Len8, {$urandom(), $urandom()});
        end
        wait_drained();
    endtask

    task automatic test_pause_mid_integer();
        logic [63:0] bits;
        sender_idle_pct = 0;
        recv_stall_pct  = 30;
        bits = {$urandom(), $urandom()};
        send_integer(pvsd_pkg::Len2, bits);
        send_byte({3'b110, bits[28:24]});
        send_byte(bits[23:16]);
        wait_drained();
        send_byte(bits[15:8]);
        send_byte(bits[7:0]);
        send_integer(pvsd_pkg::Len1, bits);
        wait_drained();
    endtask

    initial begin
        error_count     = 0;
        cycle_count     = 0;
        bytes_sent      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        owed_bytes      = '0;
        partial_value   = '0;
        total_length    = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_random_free_flow();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();
        test_pause_mid_integer();

        if (error_count == 0) begin
            $display("prefix_varint_stream_decoder_unit verification clean");
        end else begin
            $display("prefix_varint_stream_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/pvsd_pkg.sv
sv/prefix_varint_stream_decoder_unit.sv
sv/pvsd_checker.sv
sim/prefix_varint_stream_decoder_unit_test.sv
